>>> hw/rtl/wtsp_pkg.sv
package wtsp_pkg;

  // Number formats
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COEF_FRAC = 14;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned PT_W      = 32;
  localparam int unsigned LIN_W     = 3 * COEF_W;
  localparam int unsigned PROD_W    = COEF_W + PT_W;
  localparam int unsigned DOT_W     = PROD_W + 2;
  localparam int unsigned MAG_W     = DOT_W - 1;
  localparam int unsigned SCR_BITS  = 14;
  localparam int unsigned NUM_W     = MAG_W + SCR_BITS;
  localparam int unsigned CLAMP_EXP = 38;
  localparam int unsigned QUO_W     = CLAMP_EXP + FRAC_BITS;
  localparam int unsigned SUM_W     = QUO_W + 2;
  localparam int unsigned PIX_W     = 32;

  // Register port
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned IDX_LSB = 3;

  // w below this (0.001 in dot-product units) means the point is behind
  localparam logic signed [DOT_W-1:0] W_MIN =
    DOT_W'(((64'd1 << (COEF_FRAC + FRAC_BITS)) + 64'd500) / 64'd1000);

  localparam logic [PT_W-1:0]     OFF_W_RST = PT_W'(64'd1 << FRAC_BITS);
  localparam logic [SCR_BITS-1:0] SCR_W_RST = SCR_BITS'(1920);
  localparam logic [SCR_BITS-1:0] SCR_H_RST = SCR_BITS'(1080);

  typedef enum logic [2:0] {
    REG_ROW_X_LIN,
    REG_ROW_X_OFF,
    REG_ROW_Y_LIN,
    REG_ROW_Y_OFF,
    REG_ROW_W_LIN,
    REG_ROW_W_OFF,
    REG_SCR_WIDTH,
    REG_SCR_HEIGHT
  } reg_idx_e;

  // Travels alongside each word through the pipeline
  typedef struct packed {
    logic valid;
    logic front;
    logic neg_x;
    logic neg_y;
  } tag_t;

endpackage

>>> hw/rtl/wtsp_div.sv
// Pipelined restoring divider, two lanes sharing one divisor.
// One quotient bit per stage; the integer quotient is clamped at 2^CLAMP_EXP.
module wtsp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  wtsp_pkg::tag_t              tag_i,
  input  logic [wtsp_pkg::NUM_W-1:0]  num_x_i,
  input  logic [wtsp_pkg::NUM_W-1:0]  num_y_i,
  input  logic [wtsp_pkg::MAG_W-1:0]  den_i,
  output wtsp_pkg::tag_t              tag_o,
  output logic [wtsp_pkg::QUO_W:0]    quo_x_o,
  output logic [wtsp_pkg::QUO_W:0]    quo_y_o
);

  localparam int unsigned NS = wtsp_pkg::QUO_W;

  wtsp_pkg::tag_t                   tag_q [NS+1];
  logic [wtsp_pkg::MAG_W-1:0]       den_q [NS+1];
  logic [wtsp_pkg::MAG_W-1:0]       rem_q [NS+1][2];
  logic [wtsp_pkg::QUO_W-1:0]       sh_q  [NS+1][2];
  logic                             clamp_q [NS+1][2];
  logic [wtsp_pkg::NUM_W-1:0]       num [2];
  logic [wtsp_pkg::MAG_W-1:0]       num_hi [2];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      num_hi[l] = wtsp_pkg::MAG_W'(num[l][wtsp_pkg::NUM_W-1:wtsp_pkg::CLAMP_EXP]);
    end
  end

  // Entry: load the high dividend bits as partial remainder, detect clamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l]   <= num_hi[l];
        sh_q[0][l]    <= {num[l][wtsp_pkg::CLAMP_EXP-1:0], {wtsp_pkg::FRAC_BITS{1'b0}}};
        clamp_q[0][l] <= num_hi[l] >= den_i;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [wtsp_pkg::MAG_W:0] part [2];
    logic [wtsp_pkg::MAG_W:0] diff [2];
    logic                     ge   [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        part[l] = {rem_q[k][l], sh_q[k][l][wtsp_pkg::QUO_W-1]};
        diff[l] = part[l] - {1'b0, den_q[k]};
        ge[l]   = part[l] >= {1'b0, den_q[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den_q[k];
        for (int l = 0; l < 2; l++) begin
          rem_q[k+1][l]   <= ge[l] ? diff[l][wtsp_pkg::MAG_W-1:0]
                                   : part[l][wtsp_pkg::MAG_W-1:0];
          // quotient bits shift in as dividend bits shift out
          sh_q[k+1][l]    <= {sh_q[k][l][wtsp_pkg::QUO_W-2:0], ge[l]};
          clamp_q[k+1][l] <= clamp_q[k][l];
        end
      end
    end
  end

  assign tag_o   = tag_q[NS];
  assign quo_x_o = clamp_q[NS][0] ? {1'b1, {wtsp_pkg::QUO_W{1'b0}}} : {1'b0, sh_q[NS][0]};
  assign quo_y_o = clamp_q[NS][1] ? {1'b1, {wtsp_pkg::QUO_W{1'b0}}} : {1'b0, sh_q[NS][1]};

endmodule

>>> hw/rtl/world_to_screen_projection_top.sv
// Channel   Handshake                 Payload
// ------    ------------------------  ------------------------------------
// point     in_valid_i / in_ready_o   point_x_i, point_y_i, point_z_i
// pixel     out_valid_o / out_ready_i pixel_x_o, pixel_y_o, in_front_o
// config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One word enters per cycle unless a stall holds the pipeline; the depth is set by the
// one-bit-per-stage divider (38 + FRAC_BITS quotient bits) plus multiply/add stages.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// A full skid stage behind the output register halts the whole pipeline; in_ready_o
// is the inverted skid valid register and nothing is lost or repeated across a stall.
module world_to_screen_projection_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wtsp_pkg::PADDR_W-1:0]       paddr,
  input  logic [wtsp_pkg::DATA_W-1:0]        pwdata,
  output logic [wtsp_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wtsp_pkg::PT_W-1:0]   point_x_i,
  input  logic signed [wtsp_pkg::PT_W-1:0]   point_y_i,
  input  logic signed [wtsp_pkg::PT_W-1:0]   point_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wtsp_pkg::PIX_W-1:0]  pixel_x_o,
  output logic signed [wtsp_pkg::PIX_W-1:0]  pixel_y_o,
  output logic                               in_front_o
);

  localparam int unsigned F = wtsp_pkg::FRAC_BITS;

  function automatic logic [wtsp_pkg::PIX_W-1:0] sat_pix(
    input logic signed [wtsp_pkg::SUM_W-1:0] v
  );
    logic [wtsp_pkg::SUM_W-wtsp_pkg::PIX_W:0] top;
    top = v[wtsp_pkg::SUM_W-1:wtsp_pkg::PIX_W-1];
    if (top == '0 || top == '1) begin
      return v[wtsp_pkg::PIX_W-1:0];
    end else if (v[wtsp_pkg::SUM_W-1]) begin
      return {1'b1, {(wtsp_pkg::PIX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(wtsp_pkg::PIX_W-1){1'b1}}};
    end
  endfunction

  // ---------------- configuration registers ----------------
  logic [wtsp_pkg::LIN_W-1:0]    lin_q [3];
  logic [wtsp_pkg::PT_W-1:0]     off_q [3];
  logic [wtsp_pkg::SCR_BITS-1:0] scr_w_q;
  logic [wtsp_pkg::SCR_BITS-1:0] scr_h_q;
  wtsp_pkg::reg_idx_e            reg_idx;
  logic                          cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = wtsp_pkg::reg_idx_e'(paddr[wtsp_pkg::PADDR_W-1:wtsp_pkg::IDX_LSB]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q[0] <= '0;
      lin_q[1] <= '0;
      lin_q[2] <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= wtsp_pkg::OFF_W_RST;
      scr_w_q  <= wtsp_pkg::SCR_W_RST;
      scr_h_q  <= wtsp_pkg::SCR_H_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        wtsp_pkg::REG_ROW_X_LIN:  lin_q[0] <= pwdata[wtsp_pkg::LIN_W-1:0];
        wtsp_pkg::REG_ROW_X_OFF:  off_q[0] <= pwdata[wtsp_pkg::PT_W-1:0];
        wtsp_pkg::REG_ROW_Y_LIN:  lin_q[1] <= pwdata[wtsp_pkg::LIN_W-1:0];
        wtsp_pkg::REG_ROW_Y_OFF:  off_q[1] <= pwdata[wtsp_pkg::PT_W-1:0];
        wtsp_pkg::REG_ROW_W_LIN:  lin_q[2] <= pwdata[wtsp_pkg::LIN_W-1:0];
        wtsp_pkg::REG_ROW_W_OFF:  off_q[2] <= pwdata[wtsp_pkg::PT_W-1:0];
        wtsp_pkg::REG_SCR_WIDTH:  scr_w_q  <= pwdata[wtsp_pkg::SCR_BITS-1:0];
        wtsp_pkg::REG_SCR_HEIGHT: scr_h_q  <= pwdata[wtsp_pkg::SCR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wtsp_pkg::REG_ROW_X_LIN:  prdata = wtsp_pkg::DATA_W'(lin_q[0]);
      wtsp_pkg::REG_ROW_X_OFF:  prdata = wtsp_pkg::DATA_W'(off_q[0]);
      wtsp_pkg::REG_ROW_Y_LIN:  prdata = wtsp_pkg::DATA_W'(lin_q[1]);
      wtsp_pkg::REG_ROW_Y_OFF:  prdata = wtsp_pkg::DATA_W'(off_q[1]);
      wtsp_pkg::REG_ROW_W_LIN:  prdata = wtsp_pkg::DATA_W'(lin_q[2]);
      wtsp_pkg::REG_ROW_W_OFF:  prdata = wtsp_pkg::DATA_W'(off_q[2]);
      wtsp_pkg::REG_SCR_WIDTH:  prdata = wtsp_pkg::DATA_W'(scr_w_q);
      wtsp_pkg::REG_SCR_HEIGHT: prdata = wtsp_pkg::DATA_W'(scr_h_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_valid_q;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  // ---------------- stage 1: nine products ----------------
  logic signed [wtsp_pkg::PT_W-1:0]   pt [3];
  logic signed [wtsp_pkg::PROD_W-1:0] prod_d [3][3];
  logic signed [wtsp_pkg::PROD_W-1:0] prod_q [3][3];
  logic                               v1_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(lin_q[r][wtsp_pkg::COEF_W*c +: wtsp_pkg::COEF_W]) * pt[c];
      end
    end
  end

  // ---------------- stage 2: dot products ----------------
  logic signed [wtsp_pkg::DOT_W-1:0] dot_d [3];
  logic signed [wtsp_pkg::DOT_W-1:0] dot_q [3];
  logic                              v2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_d[r] = wtsp_pkg::DOT_W'(prod_q[r][0]) + wtsp_pkg::DOT_W'(prod_q[r][1])
               + wtsp_pkg::DOT_W'(prod_q[r][2])
               + wtsp_pkg::DOT_W'($signed({off_q[r], {wtsp_pkg::COEF_FRAC{1'b0}}}));
    end
  end

  // ---------------- stage 3: threshold, magnitudes ----------------
  logic [wtsp_pkg::DOT_W-1:0] abs_d [2];
  logic [wtsp_pkg::MAG_W-1:0] mag_q [2];
  logic [wtsp_pkg::MAG_W-1:0] den3_q;
  wtsp_pkg::tag_t             tag3_d;
  wtsp_pkg::tag_t             tag3_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      abs_d[l] = dot_q[l][wtsp_pkg::DOT_W-1] ? (~dot_q[l] + 1'b1) : dot_q[l];
    end
    tag3_d.valid = v2_q;
    tag3_d.front = dot_q[2] >= wtsp_pkg::W_MIN;
    tag3_d.neg_x = dot_q[0][wtsp_pkg::DOT_W-1];
    tag3_d.neg_y = dot_q[1][wtsp_pkg::DOT_W-1];
  end

  // ---------------- stage 4: scale by viewport size ----------------
  logic [wtsp_pkg::NUM_W-1:0] num_q [2];
  logic [wtsp_pkg::MAG_W-1:0] den4_q;
  wtsp_pkg::tag_t             tag4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      tag3_q <= tag3_d;
      tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= prod_d;
      dot_q    <= dot_d;
      mag_q[0] <= abs_d[0][wtsp_pkg::MAG_W-1:0];
      mag_q[1] <= abs_d[1][wtsp_pkg::MAG_W-1:0];
      den3_q   <= dot_q[2][wtsp_pkg::MAG_W-1:0];
      num_q[0] <= wtsp_pkg::NUM_W'(mag_q[0]) * wtsp_pkg::NUM_W'(scr_w_q);
      num_q[1] <= wtsp_pkg::NUM_W'(mag_q[1]) * wtsp_pkg::NUM_W'(scr_h_q);
      den4_q   <= den3_q;
    end
  end

  // ---------------- divider ----------------
  wtsp_pkg::tag_t           tag_dv;
  logic [wtsp_pkg::QUO_W:0] quo_x;
  logic [wtsp_pkg::QUO_W:0] quo_y;

  wtsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag4_q),
    .num_x_i (num_q[0]),
    .num_y_i (num_q[1]),
    .den_i   (den4_q),
    .tag_o   (tag_dv),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // ---------------- round half away, then offset into viewport ----------------
  logic [wtsp_pkg::QUO_W:0]           rsum_x;
  logic [wtsp_pkg::QUO_W:0]           rsum_y;
  logic [wtsp_pkg::QUO_W-1:0]         rnd_q [2];
  wtsp_pkg::tag_t                     tagr_q;
  logic [wtsp_pkg::SUM_W-1:0]         base_x;
  logic [wtsp_pkg::SUM_W-1:0]         base_y;
  logic [wtsp_pkg::SUM_W-1:0]         tx;
  logic [wtsp_pkg::SUM_W-1:0]         ty;
  logic signed [wtsp_pkg::SUM_W-1:0]  px_d;
  logic signed [wtsp_pkg::SUM_W-1:0]  py_d;
  logic signed [wtsp_pkg::SUM_W-1:0]  px_q;
  logic signed [wtsp_pkg::SUM_W-1:0]  py_q;
  wtsp_pkg::tag_t                     tags_q;

  assign rsum_x = quo_x + (wtsp_pkg::QUO_W+1)'(1);
  assign rsum_y = quo_y + (wtsp_pkg::QUO_W+1)'(1);

  always_comb begin
    // W/2 + 0.5 and H/2 - 0.5 in Q.F
    base_x = wtsp_pkg::SUM_W'({scr_w_q[wtsp_pkg::SCR_BITS-1:1], 1'b1, {(F-1){1'b0}}});
    base_y = wtsp_pkg::SUM_W'({scr_h_q[wtsp_pkg::SCR_BITS-1:1], {F{1'b0}}})
           - wtsp_pkg::SUM_W'({1'b1, {(F-1){1'b0}}});
    tx     = wtsp_pkg::SUM_W'(rnd_q[0]);
    ty     = wtsp_pkg::SUM_W'(rnd_q[1]);
    px_d   = tagr_q.neg_x ? $signed(base_x - tx) : $signed(base_x + tx);
    py_d   = tagr_q.neg_y ? $signed(base_y + ty) : $signed(base_y - ty);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagr_q <= '0;
      tags_q <= '0;
    end else if (en) begin
      tagr_q <= tag_dv;
      tags_q <= tagr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_q[0] <= rsum_x[wtsp_pkg::QUO_W:1];
      rnd_q[1] <= rsum_y[wtsp_pkg::QUO_W:1];
      px_q     <= px_d;
      py_q     <= py_d;
    end
  end

  // ---------------- output register and skid stage ----------------
  logic [wtsp_pkg::PIX_W-1:0] res_x;
  logic [wtsp_pkg::PIX_W-1:0] res_y;
  logic [wtsp_pkg::PIX_W-1:0] out_x_q;
  logic [wtsp_pkg::PIX_W-1:0] out_y_q;
  logic                       out_f_q;
  logic [wtsp_pkg::PIX_W-1:0] skid_x_q;
  logic [wtsp_pkg::PIX_W-1:0] skid_y_q;
  logic                       skid_f_q;
  logic                       out_valid_q;
  logic                       out_free;

  assign res_x    = tags_q.front ? sat_pix(px_q) : '0;
  assign res_y    = tags_q.front ? sat_pix(py_q) : '0;
  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain the skid word once the output is taken
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= tags_q.valid;
    end else if (tags_q.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
        out_f_q <= skid_f_q;
      end
    end else if (out_free) begin
      out_x_q <= res_x;
      out_y_q <= res_y;
      out_f_q <= tags_q.front;
    end else begin
      skid_x_q <= res_x;
      skid_y_q <= res_y;
      skid_f_q <= tags_q.front;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = $signed(out_x_q);
  assign pixel_y_o   = $signed(out_y_q);
  assign in_front_o  = out_f_q;

endmodule
